### hdl/fpn_pkg.sv
// ----------------------------------------------------------------------------
// fpn_pkg: shared types and constants of the fractal gradient noise block
// Item and configuration structs, register indexes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package fpn_pkg;

  localparam int TABLE_SIZE_DEF  = 256;
  localparam int MAX_OCTAVES_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  // opcode values
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_OCTAVE_COUNT   = 3'd0;
  localparam logic [2:0] CFG_BASE_AMPLITUDE = 3'd1;
  localparam logic [2:0] CFG_BASE_FREQUENCY = 3'd2;
  localparam logic [2:0] CFG_PERSISTENCE    = 3'd3;
  localparam logic [2:0] CFG_LACUNARITY     = 3'd4;

  // configuration reset values
  localparam logic [4:0]  OCTAVE_COUNT_RST   = 5'd4;
  localparam logic [23:0] BASE_AMPLITUDE_RST = 24'd65536;
  localparam logic [23:0] BASE_FREQUENCY_RST = 24'd65536;
  localparam logic [16:0] PERSISTENCE_RST    = 17'd32768;
  localparam logic [19:0] LACUNARITY_RST     = 20'd131072;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic [7:0]         entry_index;
    logic [7:0]         entry_value;
  } item_t;

  typedef struct packed {
    logic [4:0]  octave_count;
    logic [23:0] base_amplitude;
    logic [23:0] base_frequency;
    logic [16:0] persistence;
    logic [19:0] lacunarity;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_HASH0,
    ST_HASH1,
    ST_HASH2,
    ST_GRAD,
    ST_LERP1,
    ST_LERP2,
    ST_ACC,
    ST_DONE
  } back_state_t;

endpackage

`default_nettype wire

### hdl/fpn_ram.sv
// ----------------------------------------------------------------------------
// fpn_ram: generic RAM, one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module fpn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

### hdl/fpn_front.sv
// ----------------------------------------------------------------------------
// fpn_front: input word intake and two-entry queue
// Unpacks stream words into items and buffers them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fpn_front
  import fpn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        hold,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,
  input  wire logic [0:0]  in_tuser,
  output logic             q_valid,
  input  wire logic        q_ready,
  output item_t            q_item
);

  item_t      q_mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  item_t      in_item;
  logic       push, pop;

  always_comb begin
    in_item.opcode      = in_tuser[0];
    in_item.x_coord     = in_tdata[31:0];
    in_item.y_coord     = in_tdata[63:32];
    in_item.entry_index = in_tdata[71:64];
    in_item.entry_value = in_tdata[79:72];
  end

  assign in_tready = (cnt_r != 2'd2) && !hold;
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_item    = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

### hdl/fpn_back.sv
// ----------------------------------------------------------------------------
// fpn_back: octave sequencer and noise datapath
// Runs table loads in order, sums octaves of gradient noise per evaluate.
// ----------------------------------------------------------------------------
`default_nettype none

module fpn_back
  import fpn_pkg::*;
#(
  parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire item_t       q_item,
  output logic             clearing,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata
);

  localparam int F    = FRAC_BITS;
  localparam int AW   = $clog2(TABLE_SIZE);
  localparam int SW   = (AW > 10) ? AW : 10;
  localparam int GW   = F + 3;
  localparam int LW   = F + 4;
  localparam int CW   = $clog2(MAX_OCTAVES + 1);
  localparam int ACCW = 48;
  localparam logic signed [F+1:0]   ONE_FX = (F+2)'(1) << F;
  localparam logic signed [ACCW-1:0] SAT_HI = ACCW'(64'sh7FFFFFFF);
  localparam logic signed [ACCW-1:0] SAT_LO = -SAT_HI - ACCW'(1);

  back_state_t st_r, st_nxt;

  logic [AW-1:0]          clr_r;
  logic [31:0]            x_r, y_r;
  logic [31:0]            freq_r;
  logic [23:0]            amp_r;
  logic [CW-1:0]          oct_r;
  logic signed [ACCW-1:0] total_r;
  logic [63:0]            px_r, py_r;
  logic [7:0]             cy_r, pa_r, pb_r;
  logic [F-1:0]           fx_r, fy_r, t2x_r, t2y_r, t3x_r, t3y_r;
  logic [F+3:0]           qx_r, qy_r;
  logic [F:0]             u_r, v_r;
  logic [1:0]             haa_r, hba_r;
  logic signed [GW-1:0]   gaa_r, gba_r, gab_r, gbb_r;
  logic signed [LW-1:0]   l1_r, l2_r, nz_r;
  logic                   out_tvalid_r;
  logic [31:0]            out_tdata_r;

  // table port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_ra, ram_rb;
  logic [7:0]    ram_wdata, rd_a, rd_b;

  // datapath nets
  logic [63:0]            fix_x, fix_y;
  logic [2*F-1:0]         t2x_p, t2y_p, t3x_p, t3y_p;
  logic [F+4:0]           qx, qy;
  logic [2*F+3:0]         ux_p, vy_p;
  logic signed [F+1:0]    fxs, fys, fxm, fym;
  logic signed [GW:0]     d1, d2;
  logic signed [F+GW+2:0] p1, p2;
  logic signed [LW:0]     d3;
  logic signed [F+LW+2:0] p3;
  logic signed [LW+24:0]  amp_term;
  logic [40:0]            amp_p, amp_s;
  logic [51:0]            freq_p, freq_s;
  logic [5:0]             oct_n;
  logic                   out_free;

  function automatic logic [AW-1:0] tidx(input logic [SW-1:0] s);
    return s[AW-1:0];
  endfunction

  function automatic logic signed [GW-1:0] grad(input logic [1:0] h,
                                                input logic signed [F+1:0] gx,
                                                input logic signed [F+1:0] gy);
    logic signed [GW-1:0] uu, vv;
    uu = h[1] ? GW'(gy) : GW'(gx);
    vv = h[1] ? GW'(gx) : GW'(gy);
    if (h[0]) begin
      uu = -uu;
    end
    vv = vv <<< 1;
    if (h[1]) begin
      vv = -vv;
    end
    return uu + vv;
  endfunction

  fpn_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_ra),
    .raddr_b (ram_rb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // datapath arithmetic
  always_comb begin
    fix_x  = px_r - (x_r[31] ? {freq_r, 32'd0} : 64'd0);
    fix_y  = py_r - (y_r[31] ? {freq_r, 32'd0} : 64'd0);
    t2x_p  = fx_r * fx_r;
    t2y_p  = fy_r * fy_r;
    t3x_p  = t2x_r * fx_r;
    t3y_p  = t2y_r * fy_r;
    // 6t^2 - 15t + 10, 15t written as 16t - t
    qx     = (F+5)'({t2x_r, 2'b00}) + (F+5)'({t2x_r, 1'b0}) + ((F+5)'(10) << F)
             - (F+5)'({fx_r, 4'b0000}) + (F+5)'(fx_r);
    qy     = (F+5)'({t2y_r, 2'b00}) + (F+5)'({t2y_r, 1'b0}) + ((F+5)'(10) << F)
             - (F+5)'({fy_r, 4'b0000}) + (F+5)'(fy_r);
    ux_p   = t3x_r * qx_r;
    vy_p   = t3y_r * qy_r;
    fxs    = $signed({2'b00, fx_r});
    fys    = $signed({2'b00, fy_r});
    fxm    = fxs - ONE_FX;
    fym    = fys - ONE_FX;
    d1     = (GW+1)'(gba_r) - (GW+1)'(gaa_r);
    d2     = (GW+1)'(gbb_r) - (GW+1)'(gab_r);
    p1     = $signed({1'b0, u_r}) * d1;
    p2     = $signed({1'b0, u_r}) * d2;
    d3     = (LW+1)'(l2_r) - (LW+1)'(l1_r);
    p3     = $signed({1'b0, v_r}) * d3;
    amp_term = $signed({1'b0, amp_r}) * nz_r;
    amp_p  = amp_r * cfg.persistence;
    amp_s  = amp_p >> F;
    freq_p = freq_r * cfg.lacunarity;
    freq_s = freq_p >> F;
    oct_n  = (6'(cfg.octave_count) > 6'(MAX_OCTAVES)) ? 6'(MAX_OCTAVES)
                                                      : 6'(cfg.octave_count);
  end

  assign out_free = !out_tvalid_r || out_tready;

  // sequencer: next state and table port
  always_comb begin
    st_nxt    = st_r;
    q_ready   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = 8'(clr_r);
    ram_ra    = '0;
    ram_rb    = '0;
    case (st_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_r == AW'(TABLE_SIZE - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_item.opcode == OP_LOAD) begin
            ram_we    = 1'b1;
            ram_waddr = tidx(SW'(q_item.entry_index));
            ram_wdata = q_item.entry_value;
          end else if (oct_n == 6'd0) begin
            st_nxt = ST_DONE;
          end else begin
            st_nxt = ST_MUL;
          end
        end
      end
      ST_MUL:   st_nxt = ST_HASH0;
      ST_HASH0: begin
        ram_ra = tidx(SW'(fix_x[2*F+7 -: 8]));
        ram_rb = tidx(SW'(fix_x[2*F+7 -: 8]) + 1'b1);
        st_nxt = ST_HASH1;
      end
      ST_HASH1: begin
        ram_ra = tidx(SW'(rd_a) + SW'(cy_r));
        ram_rb = tidx(SW'(rd_b) + SW'(cy_r));
        st_nxt = ST_HASH2;
      end
      ST_HASH2: begin
        ram_ra = tidx(SW'(pa_r) + SW'(cy_r) + 1'b1);
        ram_rb = tidx(SW'(pb_r) + SW'(cy_r) + 1'b1);
        st_nxt = ST_GRAD;
      end
      ST_GRAD:  st_nxt = ST_LERP1;
      ST_LERP1: st_nxt = ST_LERP2;
      ST_LERP2: st_nxt = ST_ACC;
      ST_ACC: begin
        st_nxt = (oct_r == CW'(1)) ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_CLEAR;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (st_r == ST_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        x_r     <= q_item.x_coord;
        y_r     <= q_item.y_coord;
        freq_r  <= 32'(cfg.base_frequency);
        amp_r   <= cfg.base_amplitude;
        oct_r   <= CW'(oct_n);
        total_r <= '0;
      end
      ST_MUL: begin
        px_r <= x_r * freq_r;
        py_r <= y_r * freq_r;
      end
      ST_HASH0: begin
        cy_r <= fix_y[2*F+7 -: 8];
        fx_r <= fix_x[2*F-1 -: F];
        fy_r <= fix_y[2*F-1 -: F];
      end
      ST_HASH1: begin
        pa_r  <= rd_a;
        pb_r  <= rd_b;
        t2x_r <= t2x_p[2*F-1:F];
        t2y_r <= t2y_p[2*F-1:F];
      end
      ST_HASH2: begin
        haa_r <= rd_a[1:0];
        hba_r <= rd_b[1:0];
        t3x_r <= t3x_p[2*F-1:F];
        t3y_r <= t3y_p[2*F-1:F];
        qx_r  <= qx[F+3:0];
        qy_r  <= qy[F+3:0];
      end
      ST_GRAD: begin
        gaa_r <= grad(haa_r, fxs, fys);
        gba_r <= grad(hba_r, fxm, fys);
        gab_r <= grad(rd_a[1:0], fxs, fym);
        gbb_r <= grad(rd_b[1:0], fxm, fym);
        u_r   <= ux_p[2*F:F];
        v_r   <= vy_p[2*F:F];
      end
      ST_LERP1: begin
        l1_r <= LW'(gaa_r) + LW'(p1 >>> F);
        l2_r <= LW'(gab_r) + LW'(p2 >>> F);
      end
      ST_LERP2: begin
        nz_r <= l1_r + LW'(p3 >>> F);
      end
      ST_ACC: begin
        total_r <= total_r + ACCW'(amp_term >>> F);
        amp_r   <= (amp_s > 41'hFFFFFF) ? 24'hFFFFFF : amp_s[23:0];
        freq_r  <= (freq_s > 52'hFFFFFFFF) ? 32'hFFFFFFFF : freq_s[31:0];
        oct_r   <= oct_r - 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          if (total_r > SAT_HI) begin
            out_tdata_r <= 32'h7FFFFFFF;
          end else if (total_r < SAT_LO) begin
            out_tdata_r <= 32'h80000000;
          end else begin
            out_tdata_r <= total_r[31:0];
          end
        end
      end
      default: ;
    endcase
  end

  assign clearing   = (st_r == ST_CLEAR);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

### hdl/fractal_perlin_noise_2d.sv
// ----------------------------------------------------------------------------
// fractal_perlin_noise_2d: octave-summed 2D gradient noise, fixed point
// Streams load and evaluate words in, noise sums out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per item. in_tuser[0] is the opcode (0 load a permutation
//           entry, 1 evaluate). A load word writes the table and gives no
//           output word; an evaluate word gives exactly one out_* word.
//   out_* : noise_total, signed Q16.16, saturated to 32 bits.
//   cfg_* : register writes, taken at any edge with cfg_we high; write only
//           while the block is idle.
// Timing: words pass a two-entry queue into an eight-step octave sequencer.
//   An evaluate runs one octave at a time through the eight steps, reusing
//   the multipliers and the two-port table for each octave, with
//   octave_count capped at MAX_OCTAVES; a load is written to the table
//   from the idle state. The sequencer takes no new word until the result
//   of the last evaluate has been placed in the output register.
// Reset: rst_n (synchronous) restores the register defaults and starts a
//   pass over the table that writes the identity permutation; in_tready
//   stays low during that pass.
// Stall: a finished result waits in the output register; the queue keeps
//   taking words until it holds two, the sequencer waits only when a second
//   result is ready before the first has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fractal_perlin_noise_2d
  import fpn_pkg::*;
#(
  parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // x_coord, y_coord, entry_index, entry_value
  input  wire logic [0:0]  in_tuser,   // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // noise_total
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata
);

  cfg_t  cfg_r;
  item_t q_item;
  logic  q_valid, q_ready;
  logic  clearing;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.octave_count   <= OCTAVE_COUNT_RST;
      cfg_r.base_amplitude <= BASE_AMPLITUDE_RST;
      cfg_r.base_frequency <= BASE_FREQUENCY_RST;
      cfg_r.persistence    <= PERSISTENCE_RST;
      cfg_r.lacunarity     <= LACUNARITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OCTAVE_COUNT:   cfg_r.octave_count   <= cfg_wdata[4:0];
        CFG_BASE_AMPLITUDE: cfg_r.base_amplitude <= cfg_wdata;
        CFG_BASE_FREQUENCY: cfg_r.base_frequency <= cfg_wdata;
        CFG_PERSISTENCE:    cfg_r.persistence    <= cfg_wdata[16:0];
        CFG_LACUNARITY:     cfg_r.lacunarity     <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  // front: intake and queue
  fpn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold      (clearing),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  // back: table, octave sequencer, output register
  fpn_back #(
    .TABLE_SIZE  (TABLE_SIZE),
    .MAX_OCTAVES (MAX_OCTAVES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // no word may enter while the table is being rewritten
  a_no_accept_in_clear: assert property (@(posedge clk) clearing |-> !in_tready)
    else $error("input accepted during table clear");

  // every reset starts the clearing pass
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> clearing)
    else $error("reset did not start table clear");

  // no result can exist while the table is being rewritten
  a_no_result_in_clear: assert property (@(posedge clk) clearing |-> !out_tvalid)
    else $error("result valid during table clear");

endmodule

`default_nettype wire
